FILE: rtl/dhcpox_pkg.sv
// ----------------------------------------------------------------------------
// DHCP option extractor package
// Shared word types, the parse state encoding and the option codes.
// ----------------------------------------------------------------------------
package dhcpox_pkg;

    // One byte of the options region together with its end-of-region mark.
    typedef struct packed {
        logic [7:0] option_byte;
        logic       last_byte;
    } in_word_t;

    // The summary emitted on the last byte of a region.
    typedef struct packed {
        logic [7:0]  message_type;
        logic [31:0] lease_time;
        logic [31:0] server_address;
        logic [31:0] subnet_mask;
        logic        message_found;
        logic        lease_found;
        logic        server_found;
        logic        mask_found;
        logic        is_offer;
        logic        is_ack;
    } out_word_t;

    // Position within the type-length-value walk.
    typedef enum logic [1:0] {
        PHASE_TYPE  = 2'd0,
        PHASE_LEN   = 2'd1,
        PHASE_VALUE = 2'd2,
        PHASE_DONE  = 2'd3
    } phase_t;

    // Which captured value the current option feeds.
    typedef enum logic [2:0] {
        SLOT_NONE   = 3'd0,
        SLOT_MSG    = 3'd1,
        SLOT_LEASE  = 3'd2,
        SLOT_SERVER = 3'd3,
        SLOT_MASK   = 3'd4
    } slot_t;

    // Bit positions in the found flags.
    localparam int unsigned FOUND_MSG    = 0;
    localparam int unsigned FOUND_LEASE  = 1;
    localparam int unsigned FOUND_SERVER = 2;
    localparam int unsigned FOUND_MASK   = 3;

    localparam logic [7:0] CODE_PAD     = 8'd0;
    localparam logic [7:0] CODE_END     = 8'hff;
    localparam logic [7:0] CODE_MESSAGE = 8'd53;
    localparam logic [7:0] CODE_LEASE   = 8'd51;
    localparam logic [7:0] CODE_SERVER  = 8'd54;
    localparam logic [7:0] CODE_MASK    = 8'd1;

    localparam logic [7:0] LEN_MESSAGE  = 8'd1;
    localparam logic [7:0] LEN_WORD     = 8'd4;

    localparam logic [7:0] MSG_OFFER    = 8'd2;
    localparam logic [7:0] MSG_ACK      = 8'd5;

endpackage

FILE: rtl/dhcpox_in_reg.sv
// ----------------------------------------------------------------------------
// DHCP option extractor input register
// Holds one incoming word until the parser consumes it.
// ----------------------------------------------------------------------------
module dhcpox_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  dhcpox_pkg::in_word_t byte_word,
    input  logic                consume,
    output logic                held_valid,
    output dhcpox_pkg::in_word_t held_word
);

    logic                 valid_reg;
    logic                 valid_next;
    dhcpox_pkg::in_word_t word_reg;
    logic                 accept;

    // A held word that is not consumed this cycle blocks the sender.
    assign byte_stall = valid_reg && !consume;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= byte_word;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

FILE: rtl/dhcpox_parser.sv
// ----------------------------------------------------------------------------
// DHCP option extractor parser
// Walks the option list one byte per step and builds the region summary.
// ----------------------------------------------------------------------------
module dhcpox_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  dhcpox_pkg::in_word_t  word,
    output logic                  fire,
    output dhcpox_pkg::out_word_t result
);

    dhcpox_pkg::phase_t phase_reg, phase_next;
    logic [7:0]         code_reg, code_next;
    logic [7:0]         remain_reg, remain_next;
    dhcpox_pkg::slot_t  slot_reg, slot_next;
    logic [31:0]        shift_reg, shift_next;
    logic [7:0]         msg_reg, msg_next;
    logic [31:0]        lease_reg, lease_next;
    logic [31:0]        server_reg, server_next;
    logic [31:0]        mask_reg, mask_next;
    logic [3:0]         found_reg, found_next;

    logic [7:0]         b;
    logic [7:0]         remain_dec;
    logic               value_end;
    logic               all_found;

    // Picks the slot for an option, or none when the code is unknown, the
    // length is wrong or the value was already captured.
    function automatic dhcpox_pkg::slot_t pick_slot(
        input logic [7:0] code,
        input logic [7:0] len,
        input logic [3:0] found
    );
        dhcpox_pkg::slot_t slot;
        slot = dhcpox_pkg::SLOT_NONE;
        if (code == dhcpox_pkg::CODE_MESSAGE && len == dhcpox_pkg::LEN_MESSAGE
            && !found[dhcpox_pkg::FOUND_MSG])
        begin
            slot = dhcpox_pkg::SLOT_MSG;
        end
        else if (code == dhcpox_pkg::CODE_LEASE && len == dhcpox_pkg::LEN_WORD
            && !found[dhcpox_pkg::FOUND_LEASE])
        begin
            slot = dhcpox_pkg::SLOT_LEASE;
        end
        else if (code == dhcpox_pkg::CODE_SERVER && len == dhcpox_pkg::LEN_WORD
            && !found[dhcpox_pkg::FOUND_SERVER])
        begin
            slot = dhcpox_pkg::SLOT_SERVER;
        end
        else if (code == dhcpox_pkg::CODE_MASK && len == dhcpox_pkg::LEN_WORD
            && !found[dhcpox_pkg::FOUND_MASK])
        begin
            slot = dhcpox_pkg::SLOT_MASK;
        end
        return slot;
    endfunction

    assign b          = word.option_byte;
    assign remain_dec = remain_reg - 8'd1;
    assign value_end  = (remain_dec == 8'd0);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            dhcpox_pkg::PHASE_TYPE:
            begin
                if (b == dhcpox_pkg::CODE_END)
                begin
                    phase_next = dhcpox_pkg::PHASE_DONE;
                end
                else if (b != dhcpox_pkg::CODE_PAD)
                begin
                    phase_next = dhcpox_pkg::PHASE_LEN;
                end
            end
            dhcpox_pkg::PHASE_LEN:
            begin
                phase_next = (b == 8'd0) ? dhcpox_pkg::PHASE_TYPE
                                         : dhcpox_pkg::PHASE_VALUE;
            end
            dhcpox_pkg::PHASE_VALUE:
            begin
                if (value_end)
                begin
                    phase_next = dhcpox_pkg::PHASE_TYPE;
                end
            end
            dhcpox_pkg::PHASE_DONE:
            begin
                phase_next = dhcpox_pkg::PHASE_DONE;
            end
            default:
            begin
                phase_next = dhcpox_pkg::PHASE_TYPE;
            end
        endcase
    end

    // Datapath updates for the current phase.
    always_comb
    begin
        code_next   = code_reg;
        remain_next = remain_reg;
        slot_next   = slot_reg;
        shift_next  = shift_reg;
        msg_next    = msg_reg;
        lease_next  = lease_reg;
        server_next = server_reg;
        mask_next   = mask_reg;
        found_next  = found_reg;
        unique case (phase_reg)
            dhcpox_pkg::PHASE_TYPE:
            begin
                if (b != dhcpox_pkg::CODE_END && b != dhcpox_pkg::CODE_PAD)
                begin
                    code_next = b;
                end
            end
            dhcpox_pkg::PHASE_LEN:
            begin
                remain_next = b;
                slot_next   = pick_slot(code_reg, b, found_reg);
                shift_next  = 32'd0;
            end
            dhcpox_pkg::PHASE_VALUE:
            begin
                if (slot_reg != dhcpox_pkg::SLOT_NONE)
                begin
                    shift_next = {shift_reg[23:0], b};
                end
                remain_next = remain_dec;
                if (value_end)
                begin
                    unique case (slot_reg)
                        dhcpox_pkg::SLOT_MSG:
                        begin
                            msg_next = shift_next[7:0];
                            found_next[dhcpox_pkg::FOUND_MSG] = 1'b1;
                        end
                        dhcpox_pkg::SLOT_LEASE:
                        begin
                            lease_next = shift_next;
                            found_next[dhcpox_pkg::FOUND_LEASE] = 1'b1;
                        end
                        dhcpox_pkg::SLOT_SERVER:
                        begin
                            server_next = shift_next;
                            found_next[dhcpox_pkg::FOUND_SERVER] = 1'b1;
                        end
                        dhcpox_pkg::SLOT_MASK:
                        begin
                            mask_next = shift_next;
                            found_next[dhcpox_pkg::FOUND_MASK] = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                    slot_next = dhcpox_pkg::SLOT_NONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    // The summary reflects the byte just parsed.
    assign all_found = &found_next;
    assign fire      = step && word.last_byte;

    always_comb
    begin
        result.message_type   = msg_next;
        result.lease_time     = lease_next;
        result.server_address = server_next;
        result.subnet_mask    = mask_next;
        result.message_found  = found_next[dhcpox_pkg::FOUND_MSG];
        result.lease_found    = found_next[dhcpox_pkg::FOUND_LEASE];
        result.server_found   = found_next[dhcpox_pkg::FOUND_SERVER];
        result.mask_found     = found_next[dhcpox_pkg::FOUND_MASK];
        result.is_offer       = all_found && (msg_next == dhcpox_pkg::MSG_OFFER);
        result.is_ack         = all_found && (msg_next == dhcpox_pkg::MSG_ACK);
    end

    // The last byte of a region returns everything to the reset state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dhcpox_pkg::PHASE_TYPE;
            code_reg   <= 8'd0;
            remain_reg <= 8'd0;
            slot_reg   <= dhcpox_pkg::SLOT_NONE;
            shift_reg  <= 32'd0;
            msg_reg    <= 8'd0;
            lease_reg  <= 32'd0;
            server_reg <= 32'd0;
            mask_reg   <= 32'd0;
            found_reg  <= 4'd0;
        end
        else if (step)
        begin
            if (word.last_byte)
            begin
                phase_reg  <= dhcpox_pkg::PHASE_TYPE;
                code_reg   <= 8'd0;
                remain_reg <= 8'd0;
                slot_reg   <= dhcpox_pkg::SLOT_NONE;
                shift_reg  <= 32'd0;
                msg_reg    <= 8'd0;
                lease_reg  <= 32'd0;
                server_reg <= 32'd0;
                mask_reg   <= 32'd0;
                found_reg  <= 4'd0;
            end
            else
            begin
                phase_reg  <= phase_next;
                code_reg   <= code_next;
                remain_reg <= remain_next;
                slot_reg   <= slot_next;
                shift_reg  <= shift_next;
                msg_reg    <= msg_next;
                lease_reg  <= lease_next;
                server_reg <= server_next;
                mask_reg   <= mask_next;
                found_reg  <= found_next;
            end
        end
    end

endmodule

FILE: rtl/dhcpox_out_reg.sv
// ----------------------------------------------------------------------------
// DHCP option extractor result register
// Holds a finished summary until the receiver takes it.
// ----------------------------------------------------------------------------
module dhcpox_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  dhcpox_pkg::out_word_t load_word,
    output logic                  free,
    output logic                  result_valid,
    input  logic                  result_stall,
    output dhcpox_pkg::out_word_t result_word
);

    logic                  valid_reg;
    logic                  valid_next;
    dhcpox_pkg::out_word_t word_reg;

    // The register can take a new word when empty or being drained now.
    assign free       = !valid_reg || !result_stall;
    assign valid_next = load || (valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign result_valid = valid_reg;
    assign result_word  = word_reg;

endmodule

FILE: rtl/dhcp_option_extractor.sv
// ----------------------------------------------------------------------------
// DHCP option extractor
// Parses the DHCP options region and reports the lease-related options.
// ----------------------------------------------------------------------------
// The byte channel (byte_valid, byte_stall, byte_word) carries the options
// region one byte per word, with last_byte set on its final byte. The result
// channel (result_valid, result_stall, result_word) carries one summary word
// per region: the message type, lease time, server address and subnet mask,
// a found flag for each, and the offer and ack verdicts.
// A byte word is captured in an input register and parsed from there and,
// if it closes the region, the summary lands in the result register, from
// which it is offered to the receiver. One byte word is taken every cycle
// while no last byte is held back by a waiting summary; the parser state
// update is a single step of short logic between the input and result
// registers.
// A stall on the result channel only holds back a last byte whose summary
// has nowhere to go; ordinary bytes keep flowing while a summary waits.
// Reset clears both channel registers and returns the parser to the start of
// a region with all captured values zero. After each last byte the parser
// returns to that same state, so every region is parsed on its own.
// ----------------------------------------------------------------------------
module dhcp_option_extractor (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  dhcpox_pkg::in_word_t  byte_word,
    output logic                  result_valid,
    input  logic                  result_stall,
    output dhcpox_pkg::out_word_t result_word
);

    logic                  held_valid;
    dhcpox_pkg::in_word_t  held_word;
    logic                  out_free;
    logic                  consume;
    logic                  fire;
    dhcpox_pkg::out_word_t summary;

    // A held byte advances unless it closes the region and the result
    // register is still occupied by a summary the receiver has not taken.
    assign consume = held_valid && (!held_word.last_byte || out_free);

    dhcpox_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .consume    (consume),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    dhcpox_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (consume),
        .word   (held_word),
        .fire   (fire),
        .result (summary)
    );

    dhcpox_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire),
        .load_word    (summary),
        .free         (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

endmodule
